// ===== rtl/nmc_pkg.sv =====
package nmc_pkg;

   // Total bytes allowed for '$', body and carriage return
   localparam int unsigned MaxSentence = 256;
   localparam logic [8:0]  LongLimit   = 9'(MaxSentence - 2);

   localparam logic [7:0] CharDollar = 8'h24;
   localparam logic [7:0] CharCr     = 8'h0D;
   localparam logic [7:0] CharStar   = 8'h2A;
   localparam logic [7:0] CharComma  = 8'h2C;
   localparam logic [7:0] OffsDigit  = 8'h30;
   localparam logic [7:0] OffsUpper  = 8'h37;
   localparam logic [7:0] OffsLower  = 8'h57;

   // star phase codes
   localparam logic [1:0] PhaseBody = 2'd0;
   localparam logic [1:0] PhaseHigh = 2'd1;
   localparam logic [1:0] PhaseLow  = 2'd2;
   localparam logic [1:0] PhaseDone = 2'd3;

   // sentence kind codes
   localparam logic [2:0] KindNone = 3'd0;
   localparam logic [2:0] KindGga  = 3'd1;
   localparam logic [2:0] KindGsa  = 3'd2;
   localparam logic [2:0] KindRmc  = 3'd3;
   localparam logic [2:0] KindGsv  = 3'd4;
   localparam logic [2:0] KindVtg  = 3'd5;

   typedef struct packed {
      logic       checksum_ok;
      logic [7:0] computed_sum;
      logic [7:0] received_sum;
      logic [7:0] field_separators;
      logic [7:0] sentence_size;
      logic [2:0] sentence_kind;
      logic       overflow_seen;
      logic       hex_error;
   } nmc_result_type;

   // bit 4 set when c is not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - OffsDigit;
         return {1'b0, d[3:0]};
      end
      if (c >= 8'h41 && c <= 8'h46) begin
         d = c - OffsUpper;
         return {1'b0, d[3:0]};
      end
      if (c >= 8'h61 && c <= 8'h66) begin
         d = c - OffsLower;
         return {1'b0, d[3:0]};
      end
      return 5'h10;
   endfunction

   function automatic logic [2:0] kind_of(input logic [23:0] tri_chars);
      unique case (tri_chars)
         24'h474741: return KindGga;
         24'h475341: return KindGsa;
         24'h524D43: return KindRmc;
         24'h475356: return KindGsv;
         24'h565447: return KindVtg;
         default:    return KindNone;
      endcase
   endfunction

endpackage

// ===== rtl/nmc_parser.sv =====
module nmc_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_valid,
   input  logic [7:0]              rx_byte,
   input  logic                    check_enable,
   output logic                    result_valid,
   output nmc_pkg::nmc_result_type result
);
   import nmc_pkg::*;

   logic        in_sentence_ff, in_sentence_in;
   logic [7:0]  running_xor_ff, running_xor_in;
   logic [1:0]  star_phase_ff, star_phase_in;
   logic [3:0]  digit_high_ff, digit_high_in;
   logic [3:0]  digit_low_ff, digit_low_in;
   logic        digit_bad_ff, digit_bad_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  comma_count_ff, comma_count_in;
   logic [15:0] prior_two_ff, prior_two_in;
   logic [2:0]  kind_found_ff, kind_found_in;
   logic        too_long_ff, too_long_in;

   logic        is_dollar, is_cr;
   logic [4:0]  hex_v;
   logic [2:0]  kind_now;
   logic [7:0]  rsum;
   logic        herr;

   assign is_dollar = (rx_byte == CharDollar);
   assign is_cr     = (rx_byte == CharCr);
   assign hex_v     = hex_value(rx_byte);
   assign kind_now  = kind_of({prior_two_ff, rx_byte});
   assign rsum      = {digit_high_ff, digit_low_ff};
   assign herr      = (star_phase_ff != PhaseDone) || digit_bad_ff;

   assign result_valid = byte_valid && !is_dollar && in_sentence_ff && is_cr && check_enable;

   always_comb begin
      result.checksum_ok      = !herr && !too_long_ff && (rsum == running_xor_ff);
      result.computed_sum     = running_xor_ff;
      result.received_sum     = rsum;
      result.field_separators = comma_count_ff;
      result.sentence_size    = byte_count_ff;
      result.sentence_kind    = kind_found_ff;
      result.overflow_seen    = too_long_ff;
      result.hex_error        = herr;
   end

   always_comb begin
      in_sentence_in = in_sentence_ff;
      running_xor_in = running_xor_ff;
      star_phase_in  = star_phase_ff;
      digit_high_in  = digit_high_ff;
      digit_low_in   = digit_low_ff;
      digit_bad_in   = digit_bad_ff;
      byte_count_in  = byte_count_ff;
      comma_count_in = comma_count_ff;
      prior_two_in   = prior_two_ff;
      kind_found_in  = kind_found_ff;
      too_long_in    = too_long_ff;
      if (byte_valid) begin
         if (is_dollar) begin
            in_sentence_in = 1'b1;
            running_xor_in = 8'd0;
            star_phase_in  = PhaseBody;
            digit_high_in  = 4'd0;
            digit_low_in   = 4'd0;
            digit_bad_in   = 1'b0;
            byte_count_in  = 8'd0;
            comma_count_in = 8'd0;
            prior_two_in   = 16'd0;
            kind_found_in  = KindNone;
            too_long_in    = 1'b0;
         end else if (in_sentence_ff && is_cr) begin
            in_sentence_in = 1'b0;
         end else if (in_sentence_ff) begin
            if ({1'b0, byte_count_ff} >= LongLimit) too_long_in = 1'b1;
            if (byte_count_ff != 8'hFF) byte_count_in = byte_count_ff + 8'd1;
            if (kind_now != KindNone &&
                (kind_found_ff == KindNone || kind_now < kind_found_ff)) begin
               kind_found_in = kind_now;
            end
            prior_two_in = {prior_two_ff[7:0], rx_byte};
            unique case (star_phase_ff)
               PhaseBody: begin
                  if (rx_byte == CharStar) begin
                     star_phase_in = PhaseHigh;
                  end else begin
                     running_xor_in = running_xor_ff ^ rx_byte;
                     if (rx_byte == CharComma && comma_count_ff != 8'hFF) begin
                        comma_count_in = comma_count_ff + 8'd1;
                     end
                  end
               end
               PhaseHigh: begin
                  if (hex_v[4]) digit_bad_in = 1'b1;
                  digit_high_in = hex_v[4] ? 4'd0 : hex_v[3:0];
                  star_phase_in = PhaseLow;
               end
               PhaseLow: begin
                  if (hex_v[4]) digit_bad_in = 1'b1;
                  digit_low_in  = hex_v[4] ? 4'd0 : hex_v[3:0];
                  star_phase_in = PhaseDone;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         running_xor_ff <= 8'd0;
         star_phase_ff  <= PhaseBody;
         digit_high_ff  <= 4'd0;
         digit_low_ff   <= 4'd0;
         digit_bad_ff   <= 1'b0;
         byte_count_ff  <= 8'd0;
         comma_count_ff <= 8'd0;
         prior_two_ff   <= 16'd0;
         kind_found_ff  <= KindNone;
         too_long_ff    <= 1'b0;
      end else begin
         in_sentence_ff <= in_sentence_in;
         running_xor_ff <= running_xor_in;
         star_phase_ff  <= star_phase_in;
         digit_high_ff  <= digit_high_in;
         digit_low_ff   <= digit_low_in;
         digit_bad_ff   <= digit_bad_in;
         byte_count_ff  <= byte_count_in;
         comma_count_ff <= comma_count_in;
         prior_two_ff   <= prior_two_in;
         kind_found_ff  <= kind_found_in;
         too_long_ff    <= too_long_in;
      end
   end

endmodule

// ===== rtl/nmea_sentence_checker.sv =====
// Results: a carriage return that closes a sentence while check_enable is set produces a
//   registered result on rsp_; all other bytes produce no result.
// Throughput: one byte per cycle; the parser updates in a single pass and a
//   two-entry output stage (main register plus skid) keeps req_tready high while one
//   result waits. req_tready drops only when both output entries are full.
// Reset: synchronous, active high; clears parser state, output stage and check_enable.
module nmea_sentence_checker (
   input  logic        clock,
   input  logic        reset,
   // request stream: tdata = rx_byte[7:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // response stream: tdata = checksum_ok[0], computed_sum[8:1], received_sum[16:9],
   //   field_separators[24:17], sentence_size[32:25], overflow_seen[33],
   //   hex_error[34], zero fill[39:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // tuser = sentence_kind[2:0]
   output logic [2:0]  rsp_tuser,
   // control register write: csr_data[0] = check_enable
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import nmc_pkg::*;

   logic           check_enable_ff;
   logic           req_accept;
   logic           res_valid;
   nmc_result_type res;

   // output stage: main register drives the port, skid catches one more item
   logic           main_valid_ff, main_valid_in;
   nmc_result_type main_data_ff, main_data_in;
   logic           skid_valid_ff, skid_valid_in;
   nmc_result_type skid_data_ff, skid_data_in;
   logic           pop;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_enable_ff <= 1'b0;
      end else if (csr_valid) begin
         check_enable_ff <= csr_data;
      end
   end

   nmc_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_accept),
      .rx_byte      (req_tdata),
      .check_enable (check_enable_ff),
      .result_valid (res_valid),
      .result       (res)
   );

   assign pop = main_valid_ff && rsp_tready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // input is stalled; drain skid into main on a pop
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
            main_data_in  = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {5'd0,
                        main_data_ff.hex_error,
                        main_data_ff.overflow_seen,
                        main_data_ff.sentence_size,
                        main_data_ff.field_separators,
                        main_data_ff.received_sum,
                        main_data_ff.computed_sum,
                        main_data_ff.checksum_ok};
   assign rsp_tuser  = main_data_ff.sentence_kind;

endmodule

// ===== tb/tb_nmea_sentence_checker.sv =====
module tb_nmea_sentence_checker;
   timeunit 1ns;
   timeprecision 1ps;

   import nmc_pkg::*;

   // Watchdog. The slowest legal run is far below this: ~1.7k bytes, each with
   // at most one sender gap, plus the random stalls on the response side.
   localparam int CycleLimit   = 1_000_000;
   // Cycles allowed after the last report before touching check_enable; the
   // block registers its report after the carriage return, so this is generous.
   localparam int SettleCycles = 4;
   localparam int TailCycles   = 20;

   // ---------------------------------------------------------------------
   // Clock, reset, DUT
   // ---------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // rx_byte[7:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // checksum_ok[0], computed_sum[8:1], received_sum[16:9], field_separators[24:17],
   // sentence_size[32:25], overflow_seen[33], hex_error[34], zero fill[39:35]
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;            // sentence_kind[2:0]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;    // check_enable

   always #6 clock = ~clock;

   nmea_sentence_checker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // ---------------------------------------------------------------------
   // Sentence tracker: mirror of the parser state, updated per accepted item
   // ---------------------------------------------------------------------
   logic        check_on   = 1'b0;
   logic        open_line  = 1'b0;
   logic [7:0]  sum_acc    = 8'h00;
   logic [1:0]  star_state = PhaseBody;
   logic [3:0]  hi_nib     = 4'h0;
   logic [3:0]  lo_nib     = 4'h0;
   logic        nib_bad    = 1'b0;
   logic [7:0]  body_len   = 8'h00;
   logic [7:0]  comma_cnt  = 8'h00;
   logic [15:0] tail_chars = 16'h0000;
   logic [2:0]  kind_seen  = KindNone;
   logic        over_len   = 1'b0;

   nmc_result_type sentence_reports[$];   // reports owed by the block, oldest first
   nmc_result_type want_report;

   int failures     = 0;
   int cycles       = 0;
   int parsed_bytes = 0;     // items that reached the parser (not ignored)

   // stimulus knobs
   bit sender_burst = 1'b0;  // no gaps on the request side
   bit rsp_steady   = 1'b0;  // no stalls on the response side
   int stall_left   = 0;

   // bit 4 set for a non-hex character; letters map via their low nibble + 9
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
      if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b0, c[3:0] + 4'd9};
      return 5'h10;
   endfunction

   function automatic logic [2:0] kind_code(input logic [23:0] trio);
      if (trio == "GGA") return KindGga;
      if (trio == "GSA") return KindGsa;
      if (trio == "RMC") return KindRmc;
      if (trio == "GSV") return KindGsv;
      if (trio == "VTG") return KindVtg;
      return KindNone;
   endfunction

   function automatic logic [23:0] kind_token(input int idx);
      case (idx)
         0:       return "GGA";
         1:       return "GSA";
         2:       return "RMC";
         3:       return "GSV";
         default: return "VTG";
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return "0" + {4'd0, n};
      return (lower ? "a" : "A") + {4'd0, n} - 8'd10;
   endfunction

   // any byte that is not a hex digit, '$' or carriage return
   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      logic [4:0] v;
      c = 8'($urandom_range(0, 255));
      v = nibble_of(c);
      if (!v[4]) c = "g";
      if (c == CharDollar || c == CharCr) c = "z";
      return c;
   endfunction

   // Advance the tracker by one accepted byte; a closing CR with checking
   // on queues the report the block owes.
   task automatic absorb_byte(input logic [7:0] c);
      logic [23:0]    trio;
      logic [2:0]     k;
      logic [4:0]     nib;
      nmc_result_type r;
      if (c == CharDollar) begin
         // '$' always opens a fresh sentence, even inside one
         open_line  = 1'b1;
         sum_acc    = 8'h00;
         star_state = PhaseBody;
         hi_nib     = 4'h0;
         lo_nib     = 4'h0;
         nib_bad    = 1'b0;
         body_len   = 8'h00;
         comma_cnt  = 8'h00;
         tail_chars = 16'h0000;
         kind_seen  = KindNone;
         over_len   = 1'b0;
         return;
      end
      if (!open_line) return;
      if (c == CharCr) begin
         open_line = 1'b0;
         if (check_on) begin
            r.received_sum     = {hi_nib, lo_nib};
            r.hex_error        = (star_state != PhaseDone) || nib_bad;
            r.checksum_ok      = !r.hex_error && !over_len && (r.received_sum == sum_acc);
            r.computed_sum     = sum_acc;
            r.field_separators = comma_cnt;
            r.sentence_size    = body_len;
            r.sentence_kind    = kind_seen;
            r.overflow_seen    = over_len;
            sentence_reports.push_back(r);
         end
         return;
      end
      // '$' + body + CR must fit the buffer
      if ({1'b0, body_len} >= LongLimit) over_len = 1'b1;
      if (body_len != 8'hFF) body_len++;
      // kind: lowest code seen anywhere in the line, digits and tail included
      trio = {tail_chars, c};
      k    = kind_code(trio);
      if (k != KindNone && (kind_seen == KindNone || k < kind_seen)) kind_seen = k;
      tail_chars = trio[15:0];
      case (star_state)
         PhaseBody: begin
            if (c == CharStar) begin
               star_state = PhaseHigh;
            end else begin
               sum_acc ^= c;
               if (c == CharComma && comma_cnt != 8'hFF) comma_cnt++;
            end
         end
         PhaseHigh, PhaseLow: begin
            nib = nibble_of(c);
            if (nib[4]) begin
               nib_bad = 1'b1;
               nib     = 5'h00;
            end
            if (star_state == PhaseHigh) hi_nib = nib[3:0];
            else lo_nib = nib[3:0];
            star_state = star_state + 2'd1;
         end
         default: ;   // both digits taken: trailing bytes only count
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (sender_burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Returns at the edge that accepted the item, with tvalid still high so a
   // following item can go out back to back.
   task automatic send_byte(input logic [7:0] c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (open_line || c == CharDollar) parsed_bytes++;
      absorb_byte(c);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // '$' body '*' correct digits tail CR
   task automatic send_checked(input string body, input bit lower, input string tail);
      logic [7:0] x;
      x = 8'h00;
      for (int i = 0; i < body.len(); i++) x ^= body[i];
      send_byte(CharDollar);
      send_text(body);
      send_byte(CharStar);
      send_byte(hex_char(x[7:4], lower));
      send_byte(hex_char(x[3:0], lower));
      send_text(tail);
      send_byte(CharCr);
   endtask

   // n copies of one byte, then a checksum that matches the body
   task automatic send_long(input int n, input logic [7:0] fill);
      logic [7:0] x;
      x = n[0] ? fill : 8'h00;
      send_byte(CharDollar);
      repeat (n) send_byte(fill);
      send_byte(CharStar);
      send_byte(hex_char(x[7:4], 1'b0));
      send_byte(hex_char(x[3:0], 1'b0));
      send_byte(CharCr);
   endtask

   // Stop sending, let every owed report arrive, then let the block settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sentence_reports.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Only called with the block idle; the request side is held off meanwhile.
   task automatic write_check_enable(input logic v);
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b1;
      csr_data   <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      check_on = v;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls, short mostly, occasionally long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_steady) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 25)
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
      end
   end

   task automatic check_field(input string what, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                  $time, what, want, want, got, got);
         failures++;
      end
   endtask

   // Every accepted report is matched against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sentence_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none, got tdata 0x%h tuser %0d",
                     $time, rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want_report = sentence_reports.pop_front();
            check_field("checksum_ok",      8'(want_report.checksum_ok),
                        8'(rsp_tdata[0]));
            check_field("computed_sum",     want_report.computed_sum,     rsp_tdata[8:1]);
            check_field("received_sum",     want_report.received_sum,     rsp_tdata[16:9]);
            check_field("field_separators", want_report.field_separators, rsp_tdata[24:17]);
            check_field("sentence_size",    want_report.sentence_size,    rsp_tdata[32:25]);
            check_field("overflow_seen",    8'(want_report.overflow_seen),
                        8'(rsp_tdata[33]));
            check_field("hex_error",        8'(want_report.hex_error),
                        8'(rsp_tdata[34]));
            check_field("sentence_kind",    8'(want_report.sentence_kind),
                        8'(rsp_tuser));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("%0t: watchdog expired with %0d reports outstanding",
                  $time, sentence_reports.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed_cases();
      sender_burst = 1'b0;
      rsp_steady   = 1'b0;
      // junk outside a sentence, CR included, is dropped silently
      send_text("xyz");
      send_byte(CharCr);
      send_byte(8'hFF);
      send_byte(8'h00);
      write_check_enable(1'b1);
      send_byte(CharCr);
      // good sentences, one of each kind, both digit cases
      send_checked("GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", 1'b0, "");
      send_checked("GPRMC,081836,A,3751.65,S", 1'b1, "");
      send_checked("GPGSA,A,3,04,05,,09", 1'b0, "");
      send_checked("GPGSV,2,1,08,01", 1'b1, "");
      send_checked("GPVTG,054.7,T", 1'b0, "");
      // several kinds in one line: lowest code wins
      send_checked("GPVTG,GSA,RMC", 1'b0, "");
      // checksum mismatch
      send_text("$GPVTG,1*00");
      send_byte(CharCr);
      // non-hex digits, high then low
      send_text("$GPGSA,A*G1");
      send_byte(CharCr);
      send_text("$A*1z");
      send_byte(CharCr);
      // no asterisk at all
      send_text("$GPGGA,1,2");
      send_byte(CharCr);
      // one digit, then none
      send_text("$AB*4");
      send_byte(CharCr);
      send_text("$AB*");
      send_byte(CharCr);
      // second asterisk: as a digit it is bad, after both digits it is ignored
      send_text("$AB**5");
      send_byte(CharCr);
      send_text("$AB*03*");
      send_byte(CharCr);
      // trailing bytes still count for size and kind
      send_checked("XX", 1'b0, "RMCjunk");
      // '$' mid-sentence restarts
      send_text("$GPGGA,9,9,9");
      send_checked("AB", 1'b0, "");
      // empty sentence
      send_byte(CharDollar);
      send_byte(CharCr);
      // byte extremes in the body; sum and received sum both 0xFF
      send_byte(CharDollar);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("*FF");
      send_byte(CharCr);
      // length limit: 254 bytes after '$' still fit, 255 overflow;
      // 300 commas saturate both counters
      send_long(251, ".");
      send_long(252, ".");
      send_long(300, CharComma);
      drain_results();
   endtask

   task automatic test_check_enable();
      write_check_enable(1'b0);
      send_checked("GPGGA,1", 1'b0, "");
      send_text("$GPRMC,2");
      drain_results();
      // sentence opened while disabled, closed while enabled: reported
      write_check_enable(1'b1);
      send_text("*00");
      send_byte(CharCr);
      drain_results();
      write_check_enable(1'b0);
      send_text("$A*41");
      send_byte(CharCr);
      drain_results();
      write_check_enable(1'b1);
      send_checked("GPGSV,ok", 1'b1, "");
      drain_results();
   endtask

   // a few raw bytes between sentences, any value
   task automatic send_noise();
      int k;
      k = $urandom_range(1, 6);
      repeat (k) send_byte(8'($urandom_range(0, 255)));
   endtask

   // Mostly well-formed sentences with random content; the ending is broken
   // in every way the checker tells apart.
   task automatic send_random_sentence();
      logic [7:0]  body[$];
      logic [7:0]  x;
      logic [7:0]  c;
      logic [23:0] tok;
      int          n;
      int          pick;
      int          ending;
      n = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 40);
      while (body.size() < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            body.push_back(CharComma);
         end else if (pick < 18) begin
            tok = kind_token($urandom_range(0, 4));
            body.push_back(tok[23:16]);
            body.push_back(tok[15:8]);
            body.push_back(tok[7:0]);
         end else if (pick < 88) begin
            c = 8'($urandom_range(8'h20, 8'h7E));
            if (c == CharDollar || c == CharStar) c = "X";
            body.push_back(c);
         end else begin
            c = 8'($urandom_range(0, 255));
            if (c == CharDollar || c == CharStar || c == CharCr) c ^= 8'h80;
            body.push_back(c);
         end
      end
      x = 8'h00;
      send_byte(CharDollar);
      foreach (body[i]) begin
         x ^= body[i];
         send_byte(body[i]);
      end
      ending = $urandom_range(0, 99);
      if (ending >= 8) begin
         send_byte(CharStar);
         if (ending < 14) begin
            // asterisk, no digits
         end else if (ending < 20) begin
            send_byte(hex_char(x[7:4], 1'($urandom_range(0, 1))));
         end else if (ending < 28) begin
            send_byte(non_hex_char());
            send_byte(hex_char(x[3:0], 1'($urandom_range(0, 1))));
         end else if (ending < 36) begin
            send_byte(hex_char(x[7:4], 1'($urandom_range(0, 1))));
            send_byte(non_hex_char());
         end else begin
            if (ending < 46) x ^= 8'($urandom_range(1, 255));
            send_byte(hex_char(x[7:4], 1'($urandom_range(0, 1))));
            send_byte(hex_char(x[3:0], 1'($urandom_range(0, 1))));
         end
      end
      if ($urandom_range(0, 4) == 0) begin
         if ($urandom_range(0, 1) == 0) begin
            tok = kind_token($urandom_range(0, 4));
            send_byte(tok[23:16]);
            send_byte(tok[15:8]);
            send_byte(tok[7:0]);
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(8'h25, 8'h7E)));
         end
      end
      send_byte(CharCr);
   endtask

   task automatic test_random_traffic(input int target);
      int first;
      int lines;
      first = parsed_bytes;
      lines = 0;
      while (parsed_bytes - first < target) begin
         if ($urandom_range(0, 5) == 0) send_noise();
         send_random_sentence();
         lines++;
         // switch between idle-heavy and idle-free stretches
         if (lines % 8 == 0) begin
            sender_burst = ($urandom_range(0, 3) == 0);
            rsp_steady   = ($urandom_range(0, 4) == 0);
         end
         // pause until all reports are in, then maybe flip checking
         if (lines % 20 == 0) begin
            drain_results();
            write_check_enable($urandom_range(0, 3) != 0);
         end
      end
      drain_results();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_check_enable();
      test_random_traffic(450);
      repeat (TailCycles) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/nmc_pkg.sv
rtl/nmc_parser.sv
rtl/nmea_sentence_checker.sv
tb/tb_nmea_sentence_checker.sv
